// ===== hw/rtl/qte_pkg.sv =====
// shared types, constants and the arctangent table of the quaternion to euler block
package qte_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_LEN = 24;
  localparam int CORDIC_CELLS = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
  localparam int SQRT_CELLS = 31;
  localparam int VEC_W = 36;
  localparam int ANG_W = 28;
  localparam int RAD_W = 62;
  localparam int REM_W = 33;
  localparam int ROOT_W = 31;
  localparam int STEP_W = 5;
  localparam int DEG_W = 9;
  localparam logic signed [ANG_W-1:0] DEG180_Q16 = ANG_W'(180 * 65536);

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    zero;
  } cordic_vec_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] pn;
    logic signed [VEC_W-1:0] pd;
    logic signed [VEC_W-1:0] rn;
    logic signed [VEC_W-1:0] rd;
    logic signed [31:0]      an;
  } ops_t;

  // atan(2^-i) in degrees q12.16
  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] i);
    logic signed [ANG_W-1:0] r;
    case (i)
      5'd0:    r = 28'sd2949120;
      5'd1:    r = 28'sd1740967;
      5'd2:    r = 28'sd919879;
      5'd3:    r = 28'sd466945;
      5'd4:    r = 28'sd234379;
      5'd5:    r = 28'sd117304;
      5'd6:    r = 28'sd58666;
      5'd7:    r = 28'sd29335;
      5'd8:    r = 28'sd14668;
      5'd9:    r = 28'sd7334;
      5'd10:   r = 28'sd3667;
      5'd11:   r = 28'sd1833;
      5'd12:   r = 28'sd917;
      5'd13:   r = 28'sd458;
      5'd14:   r = 28'sd229;
      5'd15:   r = 28'sd115;
      5'd16:   r = 28'sd57;
      5'd17:   r = 28'sd29;
      5'd18:   r = 28'sd14;
      5'd19:   r = 28'sd7;
      5'd20:   r = 28'sd4;
      5'd21:   r = 28'sd2;
      5'd22:   r = 28'sd1;
      default: r = 28'sd0;
    endcase
    return r;
  endfunction

  // fold the left half plane onto the right one, flag the zero vector
  function automatic cordic_vec_t cordic_start(input logic signed [VEC_W-1:0] yv,
                                               input logic signed [VEC_W-1:0] xv);
    cordic_vec_t r;
    r.zero = (xv == '0) && (yv == '0);
    if (xv < 0) begin
      r.z = (yv >= 0) ? DEG180_Q16 : -DEG180_Q16;
      r.x = -xv;
      r.y = -yv;
    end else begin
      r.z = '0;
      r.x = xv;
      r.y = yv;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/qte_sqrt_cell.sv =====
// one result bit of the digit-by-digit integer square root
module qte_sqrt_cell (
  input  logic             clk,
  input  logic             en,
  input  qte_pkg::sqrt_st_t sin,
  output qte_pkg::sqrt_st_t sout
);

  logic [qte_pkg::REM_W+1:0] cur;
  logic [qte_pkg::REM_W+1:0] trial;
  qte_pkg::sqrt_st_t         nxt;

  always_comb begin
    cur   = {sin.rem, sin.rad[qte_pkg::RAD_W-1 -: 2]};
    trial = (qte_pkg::REM_W+2)'({sin.root, 2'b01});
    nxt.rad = {sin.rad[qte_pkg::RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      nxt.rem  = qte_pkg::REM_W'(cur - trial);
      nxt.root = {sin.root[qte_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = cur[qte_pkg::REM_W-1:0];
      nxt.root = {sin.root[qte_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sout <= nxt;
    end
  end

endmodule

// ===== hw/rtl/qte_cordic_cell.sv =====
// one vectoring iteration of the cordic arctangent
module qte_cordic_cell (
  input  logic                clk,
  input  logic                en,
  input  logic [4:0]          shift,
  input  qte_pkg::cordic_vec_t vin,
  output qte_pkg::cordic_vec_t vout
);

  logic signed [qte_pkg::VEC_W-1:0] xs;
  logic signed [qte_pkg::VEC_W-1:0] ys;
  qte_pkg::cordic_vec_t             nxt;

  always_comb begin
    xs = vin.x >>> shift;
    ys = vin.y >>> shift;
    nxt.zero = vin.zero;
    if (vin.y > 0) begin
      nxt.x = vin.x + ys;
      nxt.y = vin.y - xs;
      nxt.z = vin.z + qte_pkg::atan_q16(shift);
    end else begin
      nxt.x = vin.x - ys;
      nxt.y = vin.y + xs;
      nxt.z = vin.z - qte_pkg::atan_q16(shift);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vout <= nxt;
    end
  end

endmodule

// ===== hw/rtl/qte_quant.sv =====
// rounds a q12.16 angle to q12.7 and snaps it to a multiple of the step
module qte_quant (
  input  logic                               clk,
  input  logic                               en,
  input  logic [qte_pkg::STEP_W-1:0]         step,
  input  logic signed [qte_pkg::ANG_W-1:0]   angle,
  input  logic                               zero,
  output logic signed [qte_pkg::DEG_W-1:0]   deg
);

  // ceil(2^16 / s), entry 0 unused
  localparam logic [17:0] RECIP [32] = '{
    18'(65536), 18'(65536), 18'((65536+1)/2), 18'((65536+2)/3), 18'((65536+3)/4),
    18'((65536+4)/5), 18'((65536+5)/6), 18'((65536+6)/7), 18'((65536+7)/8),
    18'((65536+8)/9), 18'((65536+9)/10), 18'((65536+10)/11), 18'((65536+11)/12),
    18'((65536+12)/13), 18'((65536+13)/14), 18'((65536+14)/15), 18'((65536+15)/16),
    18'((65536+16)/17), 18'((65536+17)/18), 18'((65536+18)/19), 18'((65536+19)/20),
    18'((65536+20)/21), 18'((65536+21)/22), 18'((65536+22)/23), 18'((65536+23)/24),
    18'((65536+24)/25), 18'((65536+25)/26), 18'((65536+26)/27), 18'((65536+27)/28),
    18'((65536+28)/29), 18'((65536+29)/30), 18'((65536+30)/31)
  };

  logic signed [qte_pkg::ANG_W:0] ar;
  logic signed [18:0]             v;
  logic signed [18:0]             half;
  logic signed [18:0]             t;
  logic signed [11:0]             u1, u2, u3;
  logic [qte_pkg::STEP_W-1:0]     s1, s2, s3;
  logic signed [30:0]             p2;
  logic signed [14:0]             q0;
  logic signed [15:0]             m3;
  logic signed [15:0]             r;
  logic signed [15:0]             sx;
  logic signed [15:0]             o;

  always_comb begin
    ar   = (qte_pkg::ANG_W+1)'(angle) + (qte_pkg::ANG_W+1)'(256);
    v    = zero ? '0 : 19'(ar >>> 9);
    half = $signed({8'b0, step, 6'b0});
    t    = (v > 0) ? v + half : v - half;
    q0   = 15'(p2 >>> 16);
    sx   = $signed({11'b0, s3});
    r    = 16'(u3) - m3;
    if (r < 0) begin
      o = m3 - sx;
    end else if (r >= sx) begin
      o = m3 + sx;
    end else begin
      o = m3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1  <= 12'(t >>> 7);
      s1  <= step;
      p2  <= 31'(u1 * $signed({1'b0, RECIP[s1]}));
      u2  <= u1;
      s2  <= s1;
      m3  <= 16'(q0 * $signed({1'b0, s2}));
      u3  <= u2;
      s3  <= s2;
      deg <= o[qte_pkg::DEG_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/quaternion_to_quantized_euler.sv =====
// top level: quaternion in, quantized pitch, yaw and roll out
//
// channel  dir  width  content
// s_axis   in   64     quat_x, quat_y, quat_z, quat_w (q1.15)
// m_axis   out  32     pitch_deg, yaw_deg, roll_deg (whole degrees)
// cfg      in   5      angle_step_degrees
//
// one transaction per cycle sustained while the skid is empty; s_axis reaches the output register through
// 5 arithmetic stages, 31 square root cells, 1 fold stage, 16 cordic cells and 4 quantize stages
// rst is synchronous and clears only the valid bits and the step register (back to 5)
// a skid register behind the output keeps input open while a result waits; the whole
// pipe freezes only when that skid holds a result
module quaternion_to_quantized_euler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // quat_x, quat_y, quat_z, quat_w
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // pitch_deg, yaw_deg, roll_deg, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data       // angle_step_degrees
);

  localparam int CC = qte_pkg::CORDIC_CELLS;
  localparam int SC = qte_pkg::SQRT_CELLS;
  localparam int DEPTH = 5 + SC + 1 + CC + 4;
  localparam int VW = qte_pkg::VEC_W;

  // config
  logic [qte_pkg::STEP_W-1:0] step_reg;
  logic [qte_pkg::STEP_W-1:0] step_eff;

  // pipe control
  logic             en;
  logic [DEPTH-1:0] vld;
  logic             p_valid;
  logic [31:0]      p_data;
  logic             skid_valid;
  logic [31:0]      skid_data;
  logic             out_valid;
  logic [31:0]      out_data;

  // arithmetic stages
  logic signed [15:0] qx, qy, qz, qw;
  logic signed [31:0] xx, yy, zz, ww, yz, wx, xy, wz, wy, xz;
  logic signed [VW-1:0] a_full;
  qte_pkg::ops_t      ops_s2, ops_s3;
  qte_pkg::ops_t      ops_dly [SC+1];
  logic [31:0]        a_abs;
  logic [29:0]        hh;
  logic [30:0]        hl;
  logic [31:0]        ll;
  qte_pkg::sqrt_st_t  sq [SC+1];
  logic [qte_pkg::RAD_W-1:0] rad_s4;
  qte_pkg::cordic_vec_t cv [3][CC+1];
  logic signed [qte_pkg::DEG_W-1:0] deg [3];

  assign cfg_ready = 1'b1;
  assign step_eff  = (step_reg == '0) ? qte_pkg::STEP_W'(1) : step_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg <= qte_pkg::STEP_W'(5);
    end else if (cfg_valid) begin
      step_reg <= cfg_data;
    end
  end

  // pipe advances unless the skid is holding a result
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // products, sums, squared asin argument
  always_comb begin
    a_full = (VW'(wy) - VW'(xz)) <<< 1;
    a_abs  = (ops_s2.an < 0) ? 32'(-ops_s2.an) : 32'(ops_s2.an);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx <= s_axis_tdata[15:0];
      qy <= s_axis_tdata[31:16];
      qz <= s_axis_tdata[47:32];
      qw <= s_axis_tdata[63:48];

      xx <= qx * qx;
      yy <= qy * qy;
      zz <= qz * qz;
      ww <= qw * qw;
      yz <= qy * qz;
      wx <= qw * qx;
      xy <= qx * qy;
      wz <= qw * qz;
      wy <= qw * qy;
      xz <= qx * qz;

      ops_s2.pn <= (VW'(yz) + VW'(wx)) <<< 1;
      ops_s2.pd <= VW'(ww) - VW'(xx) - VW'(yy) + VW'(zz);
      ops_s2.rn <= (VW'(xy) + VW'(wz)) <<< 1;
      ops_s2.rd <= VW'(ww) + VW'(xx) - VW'(yy) - VW'(zz);
      // saturate the asin argument to +-1.0
      if (a_full > VW'(1 << 30)) begin
        ops_s2.an <= 32'sd1073741824;
      end else if (a_full < -VW'(1 << 30)) begin
        ops_s2.an <= -32'sd1073741824;
      end else begin
        ops_s2.an <= 32'(a_full);
      end

      ops_s3 <= ops_s2;
      hh <= a_abs[30:16] * a_abs[30:16];
      hl <= a_abs[30:16] * a_abs[15:0];
      ll <= a_abs[15:0] * a_abs[15:0];

      ops_dly[0] <= ops_s3;
      rad_s4 <= (qte_pkg::RAD_W'(1) << 60)
              - ((qte_pkg::RAD_W'(hh) << 32) + (qte_pkg::RAD_W'(hl) << 17)
                 + qte_pkg::RAD_W'(ll));
    end
  end

  // square root cells, pitch and roll operands ride alongside
  assign sq[0].rad  = rad_s4;
  assign sq[0].rem  = '0;
  assign sq[0].root = '0;

  for (genvar k = 0; k < SC; k++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .sin  (sq[k]),
      .sout (sq[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        ops_dly[k+1] <= ops_dly[k];
      end
    end
  end

  // fold stage: lane 0 pitch, lane 1 yaw, lane 2 roll
  always_ff @(posedge clk) begin
    if (en) begin
      cv[0][0] <= qte_pkg::cordic_start(ops_dly[SC].pn, ops_dly[SC].pd);
      cv[1][0] <= qte_pkg::cordic_start(VW'(ops_dly[SC].an), VW'(sq[SC].root));
      cv[2][0] <= qte_pkg::cordic_start(ops_dly[SC].rn, ops_dly[SC].rd);
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar i = 0; i < CC; i++) begin : g_iter
      qte_cordic_cell u_cell (
        .clk   (clk),
        .en    (en),
        .shift (5'(i)),
        .vin   (cv[l][i]),
        .vout  (cv[l][i+1])
      );
    end
    qte_quant u_quant (
      .clk   (clk),
      .en    (en),
      .step  (step_eff),
      .angle (cv[l][CC].z),
      .zero  (cv[l][CC].zero),
      .deg   (deg[l])
    );
  end

  assign p_valid = vld[DEPTH-1];
  assign p_data  = {5'b0, deg[2], deg[1], deg[0]};

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= p_valid;
      end
    end else if (p_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_data <= skid_valid ? skid_data : p_data;
    end else if (p_valid && en) begin
      skid_data <= p_data;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // skid only fills behind a waiting result
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid full with output register empty");

  // pipe stays frozen while skid is full
  a_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> $stable(vld))
    else $error("pipe moved while skid was full");

  // a result arriving at a stalled output is parked, not dropped
  a_park: assert property (@(posedge clk) disable iff (rst)
    (p_valid && en && out_valid && !m_axis_tready) |=> skid_valid)
    else $error("result lost at stalled output");

endmodule
